/* sv/assert_macros.svh */
// assertion macros shared by the compass heading rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CHC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define CHC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/chc_pkg.sv */
// shared constants, types and the arctangent table of the compass heading block
package chc_pkg;

  // angle precision of the cordic accumulator
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int TABLE_FRAC      = 20;
  localparam int TAB_SHIFT       = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam int CORDIC_ITERS    = 20;
  localparam int CIT_W           = $clog2(CORDIC_ITERS);
  localparam int INPUT_SHIFT     = 16;

  // sample, centered value and span widths
  localparam int SAMPLE_W    = 16;
  localparam int CTR_W       = SAMPLE_W + 2;
  localparam int SPAN_W      = SAMPLE_W;
  localparam int MAG_W       = SAMPLE_W;
  localparam int SCALE_SHIFT = 10;
  localparam int QUO_W       = SCALE_SHIFT + 1;
  localparam int SQ_W        = QUO_W + 1;
  localparam int DSTEP_W     = $clog2(QUO_W + 1);

  // cordic datapath widths
  localparam int CX_W = 30;
  localparam int Z_W  = ANGLE_FRAC_BITS + 9;

  // heading arithmetic
  localparam int DECL_W = 6;
  localparam int HEAD_W = 9;
  localparam int SUM_W  = 11;

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int   PADDR_W      = 3;
  localparam int   PDATA_W      = 32;
  localparam logic REG_DECL_IDX = 1'b0;

  // one classified request as queued for the back end
  typedef struct packed {
    logic                     cal;
    logic signed [CTR_W-1:0]  x_ctr;
    logic signed [CTR_W-1:0]  y_ctr;
    logic [SPAN_W-1:0]        x_span;
    logic [SPAN_W-1:0]        y_span;
  } chc_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } chc_fifo_st_t;

  // atan(2^-i) in degrees, rescaled to the accumulator precision
  function automatic logic signed [Z_W-1:0] atan_ent(input logic [CIT_W-1:0] idx);
    logic [26:0] t;
    unique case (idx)
      5'd0:    t = 27'd47185920;
      5'd1:    t = 27'd27855475;
      5'd2:    t = 27'd14718068;
      5'd3:    t = 27'd7471121;
      5'd4:    t = 27'd3750058;
      5'd5:    t = 27'd1876857;
      5'd6:    t = 27'd938658;
      5'd7:    t = 27'd469357;
      5'd8:    t = 27'd234682;
      5'd9:    t = 27'd117342;
      5'd10:   t = 27'd58671;
      5'd11:   t = 27'd29335;
      5'd12:   t = 27'd14668;
      5'd13:   t = 27'd7334;
      5'd14:   t = 27'd3667;
      5'd15:   t = 27'd1833;
      5'd16:   t = 27'd917;
      5'd17:   t = 27'd458;
      5'd18:   t = 27'd229;
      5'd19:   t = 27'd115;
      default: t = '0;
    endcase
    return Z_W'(t >> TAB_SHIFT);
  endfunction

endpackage

/* sv/compass_heading_autocal.sv */
// compass heading with min/max hard-iron autocalibration, top level
// a calibrated request passes intake, queue, 11 divider steps and handoff, 20 cordic steps,
//   fix and output; the cordic is skipped when scaled x is zero, and an uncalibrated request
//   goes from the queue to the output; the back end takes its next request only after the
//   last one's result has been loaded into the output register
// reset: synchronous active-low rst_n clears extremes, declination, queue and control
`include "assert_macros.svh"

module compass_heading_autocal import chc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_x_sample,
  input  logic signed [SAMPLE_W-1:0] in_y_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [HEAD_W-1:0]   out_heading_deg,
  output logic                       out_heading_valid,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  logic signed [DECL_W-1:0] decl_r, decl_nxt;
  logic                     cfg_wr;
  chc_fifo_st_t             fst;
  chc_item_t                wr_item, rd_item;
  logic                     push, pop, front_cal;
  logic                     out_uncal, out_cal, head_in_range;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    decl_nxt = decl_r;
    if (cfg_wr && (paddr[PADDR_W-1] == REG_DECL_IDX)) begin
      decl_nxt = pwdata[DECL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decl_r <= '0;
    end else begin
      decl_r <= decl_nxt;
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_DECL_IDX) ? PDATA_W'(decl_r) : '0;

  // front end, queue, back end
  chc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_x_sample (in_x_sample),
    .in_y_sample (in_y_sample),
    .fst         (fst),
    .push        (push),
    .item        (wr_item),
    .cal         (front_cal)
  );

  chc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .st      (fst)
  );

  chc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fst               (fst),
    .item              (rd_item),
    .pop               (pop),
    .decl              (decl_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_heading_deg   (out_heading_deg),
    .out_heading_valid (out_heading_valid)
  );

  // checks
  assign out_uncal     = out_valid && !out_heading_valid;
  assign out_cal       = out_valid && out_heading_valid;
  assign head_in_range = (out_heading_deg >= -180) && (out_heading_deg <= 180);

  `CHC_ASSERT_IMP(a_uncal_zero, out_uncal, out_heading_deg == '0, "uncalibrated heading nonzero")
  `CHC_ASSERT_IMP(a_head_range, out_valid, head_in_range, "heading outside -180..180")
  `CHC_ASSERT_NXT(a_cal_sticky, front_cal, front_cal, "calibration lost")
  `CHC_ASSERT_IMP(a_valid_cal, out_cal, front_cal, "valid heading without calibration")

endmodule

/* sv/chc_front.sv */
// front end: sample intake, min/max tracking and classification into the queue
module chc_front import chc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_x_sample,
  input  logic signed [SAMPLE_W-1:0] in_y_sample,
  input  chc_fifo_st_t               fst,
  output logic                       push,
  output chc_item_t                  item,
  output logic                       cal
);

  logic                       pend_r, pend_nxt;
  logic signed [SAMPLE_W-1:0] xs_r, ys_r;
  logic signed [SAMPLE_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic signed [SAMPLE_W-1:0] x_min_nxt, x_max_nxt, y_min_nxt, y_max_nxt;
  logic                       accept;
  logic signed [SAMPLE_W:0]   xsum, ysum, xmid, ymid, xdiff, ydiff;

  // one pending request; a new one is taken as the old one leaves
  assign push     = pend_r && !fst.full;
  assign in_ready = !pend_r || !fst.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (push) begin
      pend_nxt = 1'b0;
    end
  end

  // widen the running extremes with the new sample
  always_comb begin
    x_min_nxt = x_min_r;
    x_max_nxt = x_max_r;
    y_min_nxt = y_min_r;
    y_max_nxt = y_max_r;
    if (accept) begin
      if (in_x_sample < x_min_r) begin
        x_min_nxt = in_x_sample;
      end else if (in_x_sample > x_max_r) begin
        x_max_nxt = in_x_sample;
      end
      if (in_y_sample < y_min_r) begin
        y_min_nxt = in_y_sample;
      end else if (in_y_sample > y_max_r) begin
        y_max_nxt = in_y_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      x_min_r <= '0;
      x_max_r <= '0;
      y_min_r <= '0;
      y_max_r <= '0;
    end else begin
      pend_r  <= pend_nxt;
      x_min_r <= x_min_nxt;
      x_max_r <= x_max_nxt;
      y_min_r <= y_min_nxt;
      y_max_r <= y_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xs_r <= in_x_sample;
      ys_r <= in_y_sample;
    end
  end

  // hard-iron midpoint, truncated toward zero
  always_comb begin
    xsum  = (SAMPLE_W+1)'(x_min_r) + (SAMPLE_W+1)'(x_max_r);
    ysum  = (SAMPLE_W+1)'(y_min_r) + (SAMPLE_W+1)'(y_max_r);
    xmid  = (xsum + $signed({{SAMPLE_W{1'b0}}, xsum[SAMPLE_W]})) >>> 1;
    ymid  = (ysum + $signed({{SAMPLE_W{1'b0}}, ysum[SAMPLE_W]})) >>> 1;
    xdiff = (SAMPLE_W+1)'(x_max_r) - (SAMPLE_W+1)'(x_min_r);
    ydiff = (SAMPLE_W+1)'(y_max_r) - (SAMPLE_W+1)'(y_min_r);
  end

  // classification and centered values for the back end
  assign cal         = (x_min_r != x_max_r) && (y_min_r != y_max_r);
  assign item.cal    = cal;
  assign item.x_ctr  = CTR_W'(xs_r) - CTR_W'(xmid);
  assign item.y_ctr  = CTR_W'(ys_r) - CTR_W'(ymid);
  assign item.x_span = xdiff[SPAN_W-1:0];
  assign item.y_span = ydiff[SPAN_W-1:0];

endmodule

/* sv/chc_fifo.sv */
// short request queue between the front and back ends
module chc_fifo import chc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  chc_item_t    wr_item,
  input  logic         pop,
  output chc_item_t    rd_item,
  output chc_fifo_st_t st
);

  chc_item_t         mem_r [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] cnt_r, cnt_nxt;

  assign st.full  = (cnt_r == FCNT_W'(FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);
  assign rd_item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* sv/chc_div.sv */
// radix-2 restoring divider: centered value * 1024 / span, truncated toward zero
module chc_div import chc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [CTR_W-1:0] ctr,
  input  logic [SPAN_W-1:0]       span,
  output logic                    done,
  output logic signed [SQ_W-1:0]  quo
);

  localparam int NUM_W = MAG_W + SCALE_SHIFT;

  logic                    busy_r, busy_nxt, done_r, done_nxt;
  logic [DSTEP_W-1:0]      step_r, step_nxt;
  logic [SPAN_W-1:0]       rem_r, rem_nxt, span_r;
  logic [QUO_W-1:0]        sh_r, sh_nxt, q_r, q_nxt;
  logic                    neg_r;
  logic signed [CTR_W-1:0] neg_ctr;
  logic [MAG_W-1:0]        mag;
  logic [NUM_W-1:0]        num;
  logic [SPAN_W:0]         trial;
  logic                    ge;
  logic signed [SQ_W-1:0]  qs;

  // magnitude of the scaled dividend; the high part is already below the span
  assign neg_ctr = -ctr;
  assign mag     = ctr[CTR_W-1] ? MAG_W'(neg_ctr) : MAG_W'(ctr);
  assign num     = {mag, {SCALE_SHIFT{1'b0}}};

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, sh_r[QUO_W-1]};
    ge       = trial >= {1'b0, span_r};
    rem_nxt  = ge ? SPAN_W'(trial - {1'b0, span_r}) : SPAN_W'(trial);
    sh_nxt   = sh_r << 1;
    q_nxt    = {q_r[QUO_W-2:0], ge};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = DSTEP_W'(QUO_W);
    end else if (busy_r) begin
      step_nxt = step_r - 1'b1;
      if (step_r == DSTEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= SPAN_W'(num[NUM_W-1:QUO_W]);
      sh_r   <= num[QUO_W-1:0];
      q_r    <= '0;
      span_r <= span;
      neg_r  <= ctr[CTR_W-1];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
      q_r   <= q_nxt;
    end
  end

  // signed quotient
  assign qs   = $signed({1'b0, q_r});
  assign quo  = neg_r ? -qs : qs;
  assign done = done_r;

endmodule

/* sv/chc_back.sv */
// back end: axis scaling, cordic arctangent, heading fixup and result register
module chc_back import chc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  chc_fifo_st_t             fst,
  input  chc_item_t                item,
  output logic                     pop,
  input  logic signed [DECL_W-1:0] decl,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [HEAD_W-1:0] out_heading_deg,
  output logic                     out_heading_valid
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CORD = 3'd2;
  localparam logic [2:0] ST_FIX  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic signed [SUM_W-1:0] DEG_90  = SUM_W'(90);
  localparam logic signed [SUM_W-1:0] DEG_180 = SUM_W'(180);
  localparam logic signed [SUM_W-1:0] DEG_360 = SUM_W'(360);

  logic [2:0]               st_r, st_nxt;
  logic [CIT_W-1:0]         it_r, it_nxt;
  logic signed [CX_W-1:0]   cx_r, cx_nxt, cy_r, cy_nxt, dx, dy;
  logic signed [Z_W-1:0]    z_r, z_nxt, ang, zabs;
  logic [Z_W-1:0]           zint;
  logic                     xzero_r, xzero_nxt, xneg_r, xneg_nxt;
  logic                     ypos_r, ypos_nxt, yneg_r, yneg_nxt;
  logic signed [HEAD_W-1:0] res_h_r, res_h_nxt;
  logic                     res_v_r, res_v_nxt;
  logic                     out_valid_r, out_valid_nxt, load;
  logic signed [HEAD_W-1:0] out_h_r;
  logic                     out_v_r;
  logic                     div_start, div_x_done, div_y_done;
  logic signed [SQ_W-1:0]   quo_x, quo_y, qx_abs, qy_adj;
  logic signed [SUM_W-1:0]  atan_v, zi, comp, hsum, hwrap;

  // dividers for the two axes run side by side
  chc_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .ctr   (item.x_ctr),
    .span  (item.x_span),
    .done  (div_x_done),
    .quo   (quo_x)
  );

  chc_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .ctr   (item.y_ctr),
    .span  (item.y_span),
    .done  (div_y_done),
    .quo   (quo_y)
  );

  assign pop       = (st_r == ST_IDLE) && !fst.empty;
  assign div_start = pop && item.cal;

  // cordic step operands
  assign dx  = cy_r >>> it_r;
  assign dy  = cx_r >>> it_r;
  assign ang = atan_ent(it_r);

  // vector turned through 180 degrees into the right half plane when x is negative
  assign qx_abs = quo_x[SQ_W-1] ? -quo_x : quo_x;
  assign qy_adj = quo_x[SQ_W-1] ? -quo_y : quo_y;

  // whole degrees truncated toward zero, quadrant fix, declination and wrap
  always_comb begin
    zabs = z_r[Z_W-1] ? -z_r : z_r;
    zint = zabs >> ANGLE_FRAC_BITS;
    zi   = SUM_W'(zint);
    if (xzero_r) begin
      atan_v = ypos_r ? DEG_90 : (yneg_r ? -DEG_90 : '0);
    end else begin
      atan_v = z_r[Z_W-1] ? -zi : zi;
    end
    comp = '0;
    if (xneg_r) begin
      comp = ypos_r ? DEG_180 : -DEG_180;
    end
    hsum = atan_v + SUM_W'(decl) + comp;
    if (hsum < -DEG_180) begin
      hwrap = hsum + DEG_360;
    end else if (hsum > DEG_180) begin
      hwrap = hsum - DEG_360;
    end else begin
      hwrap = hsum;
    end
  end

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    it_nxt    = it_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    z_nxt     = z_r;
    xzero_nxt = xzero_r;
    xneg_nxt  = xneg_r;
    ypos_nxt  = ypos_r;
    yneg_nxt  = yneg_r;
    res_h_nxt = res_h_r;
    res_v_nxt = res_v_r;
    load      = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (pop) begin
          if (item.cal) begin
            st_nxt = ST_DIV;
          end else begin
            res_h_nxt = '0;
            res_v_nxt = 1'b0;
            st_nxt    = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_x_done && div_y_done) begin
          xzero_nxt = (quo_x == '0);
          xneg_nxt  = quo_x[SQ_W-1];
          ypos_nxt  = !quo_y[SQ_W-1] && (quo_y != '0);
          yneg_nxt  = quo_y[SQ_W-1];
          cx_nxt    = CX_W'(qx_abs) <<< INPUT_SHIFT;
          cy_nxt    = CX_W'(qy_adj) <<< INPUT_SHIFT;
          z_nxt     = '0;
          it_nxt    = '0;
          st_nxt    = (quo_x == '0) ? ST_FIX : ST_CORD;
        end
      end
      ST_CORD: begin
        if (!cy_r[CX_W-1]) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + ang;
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - ang;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == CIT_W'(CORDIC_ITERS - 1)) begin
          st_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        res_h_nxt = HEAD_W'(hwrap);
        res_v_nxt = 1'b1;
        st_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load   = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r    <= it_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    z_r     <= z_nxt;
    xzero_r <= xzero_nxt;
    xneg_r  <= xneg_nxt;
    ypos_r  <= ypos_nxt;
    yneg_r  <= yneg_nxt;
    res_h_r <= res_h_nxt;
    res_v_r <= res_v_nxt;
    if (load) begin
      out_h_r <= res_h_r;
      out_v_r <= res_v_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_heading_deg   = out_h_r;
  assign out_heading_valid = out_v_r;

endmodule
